// ----- rtl/lsf_pkg.sv -----
// Shared constants, codes and types of the laser-sweep frame generator.
`default_nettype none
package lsf_pkg;

    localparam int DISPLAY_COLS    = 44;
    localparam int MAX_BITMAP_COLS = 1024;
    localparam int PAGE_STEPS      = 3 * DISPLAY_COLS;
    localparam int QUEUE_DEPTH     = 4;

    localparam int COL_AW = $clog2(MAX_BITMAP_COLS);
    localparam int WID_W  = $clog2(MAX_BITMAP_COLS + 1);
    localparam int CNT_W  = $clog2(DISPLAY_COLS + 1);
    localparam int STEP_W = $clog2(PAGE_STEPS);
    localparam int QP_W   = $clog2(QUEUE_DEPTH);
    localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);

    localparam int OPC_W  = 2;
    localparam int PIX_W  = 16;
    localparam int LCOL_W = 6;
    localparam int POS_W  = 12;

    typedef enum logic [OPC_W-1:0] {
        OP_WRITE   = 2'd0,
        OP_TICK    = 2'd1,
        OP_RESTART = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode                 op;
        logic [COL_AW-1:0]       addr;
        logic [PIX_W-1:0]        value;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POS,
        ST_SCAN,
        ST_CALC,
        ST_EMIT
    } t_back_state;

    typedef enum logic [1:0] {
        PH_IN,
        PH_STILL,
        PH_OUT
    } t_phase;

endpackage
`default_nettype wire

// ----- rtl/lsf_ram.sv -----
// Generic single-port RAM with registered read.
`default_nettype none
module lsf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- rtl/lsf_front.sv -----
// Front end: accepts input requests, drops unused opcodes, queues commands.
`default_nettype none
module lsf_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [lsf_pkg::OPC_W-1:0]   i_opcode,
    input  wire logic [lsf_pkg::COL_AW-1:0]  i_column_address,
    input  wire logic [lsf_pkg::PIX_W-1:0]   i_column_value,
    output logic                             o_q_valid,
    output lsf_pkg::t_cmd                    o_q_cmd,
    input  wire logic                        i_q_take
);
    import lsf_pkg::*;

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [QP_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QP_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QC_W-1:0]  r_count,  n_count;
    logic             push;
    logic             pop;
    t_cmd             in_cmd;

    assign o_in_stall = (r_count == QC_W'(QUEUE_DEPTH));
    assign in_cmd     = '{op: t_opcode'(i_opcode), addr: i_column_address,
                          value: i_column_value};
    assign push       = i_in_valid && !o_in_stall && (in_cmd.op != OP_NONE);
    assign pop        = i_q_take && o_q_valid;
    assign o_q_valid  = (r_count != '0);
    assign o_q_cmd    = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= in_cmd;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/lsf_back.sv -----
// Back end: bitmap store, position counter, page centering and frame emission.
`default_nettype none
module lsf_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    input  wire logic [lsf_pkg::WID_W-1:0]   i_cfg_data,
    input  wire logic                        i_q_valid,
    input  wire lsf_pkg::t_cmd               i_q_cmd,
    output logic                             o_q_take,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [lsf_pkg::LCOL_W-1:0]       o_led_column,
    output logic [lsf_pkg::PIX_W-1:0]        o_pixel_bits,
    output logic                             o_last_column,
    output logic [lsf_pkg::POS_W-1:0]        o_cycle_position
);
    import lsf_pkg::*;

    localparam logic [WID_W-1:0]  COLS_WID  = WID_W'(DISPLAY_COLS);
    localparam logic [WID_W-1:0]  MAX_WID   = WID_W'(MAX_BITMAP_COLS);
    localparam logic [POS_W-1:0]  STEPS_POS = POS_W'(PAGE_STEPS);
    localparam logic [CNT_W-1:0]  COLS_CNT  = CNT_W'(DISPLAY_COLS);
    localparam logic [CNT_W:0]    COLS_CW1  = (CNT_W + 1)'(DISPLAY_COLS);
    localparam logic [CNT_W-1:0]  LAST_J    = CNT_W'(DISPLAY_COLS - 1);
    localparam logic [STEP_W-1:0] C_STILL   = STEP_W'(DISPLAY_COLS);
    localparam logic [STEP_W-1:0] C_OUT     = STEP_W'(2 * DISPLAY_COLS);
    localparam logic [POS_W-1:0]  LAST_STEP = POS_W'(PAGE_STEPS - 1);

    t_back_state         r_state, n_state;
    logic [WID_W-1:0]    r_width, n_width;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [POS_W-1:0]    r_rem, n_rem;
    logic [WID_W-1:0]    r_start, n_start;
    logic [POS_W-1:0]    r_base, n_base;
    logic [STEP_W-1:0]   r_c, n_c;
    logic [CNT_W-1:0]    r_scan_n, n_scan_n;
    logic [CNT_W-1:0]    r_k, n_k;
    logic                r_rd_vld, n_rd_vld;
    logic [CNT_W-1:0]    r_rd_k, n_rd_k;
    logic [CNT_W-1:0]    r_content, n_content;
    logic [CNT_W-1:0]    r_off, n_off;
    logic [CNT_W-1:0]    r_rr, n_rr;
    logic [CNT_W-1:0]    r_live_end, n_live_end;
    t_phase              r_phase, n_phase;
    logic [CNT_W-1:0]    r_j, n_j;
    logic                r_issue_done, n_issue_done;
    logic                r_b_vld, n_b_vld;
    logic                r_b_use, n_b_use;
    logic [CNT_W-1:0]    r_b_j, n_b_j;
    logic                r_ovld, n_ovld;
    logic [LCOL_W-1:0]   r_ocol, n_ocol;
    logic [PIX_W-1:0]    r_opix, n_opix;
    logic                r_olast, n_olast;
    logic [POS_W-1:0]    r_opos, n_opos;

    logic                ram_we;
    logic                ram_re;
    logic [COL_AW-1:0]   ram_addr;
    logic [PIX_W-1:0]    ram_rdata;

    logic                page_wrap;
    logic                rem_ge;
    logic [WID_W-1:0]    remain;
    logic [CNT_W-1:0]    scan_n;
    logic [POS_W-1:0]    next_pos;
    logic [WID_W-1:0]    scan_idx;
    logic [CNT_W-1:0]    off;
    logic [CNT_W-1:0]    span;
    logic [CNT_W-1:0]    lim;
    logic [CNT_W:0]      s_in;
    logic [CNT_W:0]      r_in;
    logic [CNT_W-1:0]    d_out;
    logic [CNT_W-1:0]    r_outv;
    logic [CNT_W-1:0]    jo;
    logic [CNT_W:0]      off_r;
    logic [CNT_W:0]      j_ext;
    logic [WID_W-1:0]    idx_bm;
    logic [WID_W-1:0]    idx_beam;
    logic [WID_W-1:0]    idx;
    logic                sel_bm;
    logic                sel_beam;
    logic                use_col;
    logic                out_free;
    logic                advance;
    logic [WID_W-1:0]    cfg_width;

    lsf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_BITMAP_COLS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (i_q_cmd.value),
        .o_rdata (ram_rdata)
    );

    // width clamp: zero acts as one, oversize acts as store depth
    assign cfg_width = (i_cfg_data == '0)    ? WID_W'(1) :
                       (i_cfg_data > MAX_WID) ? MAX_WID   : i_cfg_data;

    // position reduction and scan setup
    assign page_wrap = (r_start + COLS_WID) >= r_width;
    assign rem_ge    = r_rem >= STEPS_POS;
    assign remain    = r_width - r_start;
    assign scan_n    = (remain >= COLS_WID) ? COLS_CNT : remain[CNT_W-1:0];
    assign next_pos  = (r_rem == LAST_STEP && page_wrap) ? '0 :
                       r_base + r_rem + POS_W'(1);
    assign scan_idx  = r_start + WID_W'(r_k);

    // centering and sweep offset
    assign off    = (r_content < COLS_CNT) ? ((COLS_CNT - r_content) >> 1) : '0;
    assign span   = COLS_CNT - off;
    assign lim    = (span < r_scan_n) ? span : r_scan_n;
    assign s_in   = (CNT_W + 1)'(r_c[CNT_W-1:0]) + (CNT_W + 1)'(span);
    assign r_in   = (s_in >= COLS_CW1) ? s_in - COLS_CW1
                                       : s_in + (CNT_W + 1)'(span) - COLS_CW1;
    assign d_out  = CNT_W'(r_c - C_OUT);
    assign r_outv = (d_out >= span) ? d_out - span : d_out;

    // column source for emission
    assign jo       = r_j - r_off;
    assign off_r    = (CNT_W + 1)'(r_off) + (CNT_W + 1)'(r_rr);
    assign j_ext    = (CNT_W + 1)'(r_j);
    assign idx_bm   = r_start + WID_W'(jo);
    assign idx_beam = r_start + WID_W'(r_rr);

    always_comb begin
        sel_bm   = 1'b0;
        sel_beam = 1'b0;
        case (r_phase)
            PH_IN: begin
                if (r_j >= r_off) begin
                    if (j_ext < off_r) begin
                        sel_bm = 1'b1;
                    end else if (r_j < r_live_end) begin
                        sel_beam = 1'b1;
                    end
                end
            end
            PH_STILL: begin
                sel_bm = (r_j >= r_off);
            end
            PH_OUT: begin
                sel_bm = (j_ext >= off_r) && (r_j < r_live_end);
            end
            default: begin
                sel_bm = 1'b0;
            end
        endcase
    end

    assign idx     = sel_beam ? idx_beam : idx_bm;
    assign use_col = (sel_bm || sel_beam) && (idx < r_width);

    assign out_free = !r_ovld || !i_out_stall;
    assign advance  = !r_b_vld || out_free;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid && i_q_cmd.op == OP_TICK) begin
                    n_state = ST_POS;
                end
            end
            ST_POS: begin
                if (!rem_ge) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_k == r_scan_n && !r_rd_vld) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (r_issue_done && !r_b_vld) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_width      = i_cfg_valid ? cfg_width : r_width;
        n_pos        = r_pos;
        n_rem        = r_rem;
        n_start      = r_start;
        n_base       = r_base;
        n_c          = r_c;
        n_scan_n     = r_scan_n;
        n_k          = r_k;
        n_rd_vld     = r_rd_vld;
        n_rd_k       = r_rd_k;
        n_content    = r_content;
        n_off        = r_off;
        n_rr         = r_rr;
        n_live_end   = r_live_end;
        n_phase      = r_phase;
        n_j          = r_j;
        n_issue_done = r_issue_done;
        n_b_vld      = r_b_vld;
        n_b_use      = r_b_use;
        n_b_j        = r_b_j;
        n_ovld       = r_ovld && i_out_stall;
        n_ocol       = r_ocol;
        n_opix       = r_opix;
        n_olast      = r_olast;
        n_opos       = r_opos;
        o_q_take     = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_addr     = i_q_cmd.addr;

        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_take = 1'b1;
                    case (i_q_cmd.op)
                        OP_WRITE: begin
                            ram_we = 1'b1;
                        end
                        OP_RESTART: begin
                            n_pos = '0;
                        end
                        OP_TICK: begin
                            n_rem   = r_pos;
                            n_start = '0;
                            n_base  = '0;
                        end
                        default: begin
                            n_pos = r_pos;
                        end
                    endcase
                end
            end
            ST_POS: begin
                if (rem_ge) begin
                    n_rem = r_rem - STEPS_POS;
                    if (page_wrap) begin
                        n_start = '0;
                        n_base  = '0;
                    end else begin
                        n_start = r_start + COLS_WID;
                        n_base  = r_base + STEPS_POS;
                    end
                end else begin
                    n_c       = r_rem[STEP_W-1:0];
                    n_pos     = next_pos;
                    n_scan_n  = scan_n;
                    n_k       = '0;
                    n_content = '0;
                    n_rd_vld  = 1'b0;
                end
            end
            ST_SCAN: begin
                if (r_rd_vld && ram_rdata != '0) begin
                    n_content = r_rd_k + 1'b1;
                end
                if (r_k != r_scan_n) begin
                    ram_re   = 1'b1;
                    ram_addr = scan_idx[COL_AW-1:0];
                    n_rd_vld = 1'b1;
                    n_rd_k   = r_k;
                    n_k      = r_k + 1'b1;
                end else begin
                    n_rd_vld = 1'b0;
                end
            end
            ST_CALC: begin
                n_off      = off;
                n_live_end = off + lim;
                if (r_c < C_STILL) begin
                    n_phase = PH_IN;
                    n_rr    = r_in[CNT_W-1:0];
                end else if (r_c < C_OUT) begin
                    n_phase = PH_STILL;
                    n_rr    = '0;
                end else begin
                    n_phase = PH_OUT;
                    n_rr    = r_outv;
                end
                n_j          = '0;
                n_issue_done = 1'b0;
                n_b_vld      = 1'b0;
            end
            ST_EMIT: begin
                if (advance) begin
                    if (r_b_vld) begin
                        n_ovld  = 1'b1;
                        n_ocol  = LCOL_W'(r_b_j);
                        n_opix  = r_b_use ? ram_rdata : '0;
                        n_olast = (r_b_j == LAST_J);
                        n_opos  = r_pos;
                    end
                    if (!r_issue_done) begin
                        ram_re   = use_col;
                        ram_addr = idx[COL_AW-1:0];
                        n_b_vld  = 1'b1;
                        n_b_j    = r_j;
                        n_b_use  = use_col;
                        if (r_j == LAST_J) begin
                            n_issue_done = 1'b1;
                        end else begin
                            n_j = r_j + 1'b1;
                        end
                    end else begin
                        n_b_vld = 1'b0;
                    end
                end
            end
            default: begin
                n_ovld = r_ovld && i_out_stall;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_width      <= WID_W'(1);
            r_pos        <= '0;
            r_rd_vld     <= 1'b0;
            r_issue_done <= 1'b0;
            r_b_vld      <= 1'b0;
            r_ovld       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_width      <= n_width;
            r_pos        <= n_pos;
            r_rd_vld     <= n_rd_vld;
            r_issue_done <= n_issue_done;
            r_b_vld      <= n_b_vld;
            r_ovld       <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem      <= n_rem;
        r_start    <= n_start;
        r_base     <= n_base;
        r_c        <= n_c;
        r_scan_n   <= n_scan_n;
        r_k        <= n_k;
        r_rd_k     <= n_rd_k;
        r_content  <= n_content;
        r_off      <= n_off;
        r_rr       <= n_rr;
        r_live_end <= n_live_end;
        r_phase    <= n_phase;
        r_j        <= n_j;
        r_b_use    <= n_b_use;
        r_b_j      <= n_b_j;
        r_ocol     <= n_ocol;
        r_opix     <= n_opix;
        r_olast    <= n_olast;
        r_opos     <= n_opos;
    end

    assign o_out_valid      = r_ovld;
    assign o_led_column     = r_ocol;
    assign o_pixel_bits     = r_opix;
    assign o_last_column    = r_olast;
    assign o_cycle_position = r_opos;

endmodule
`default_nettype wire

// ----- rtl/led_laser_sweep_frames_unit.sv -----
// Top level of the laser-sweep LED frame generator.
// A write request stores one 16-bit bitmap column, a restart request clears
// the position, and a tick request emits one frame of 44 columns, one column
// per output request, with the new position in every column. Requests
// enter a four-deep command queue, so input is taken while a frame is still
// being emitted. Write and restart complete in the back end's idle state. A
// tick proceeds in steps: the idle state takes the request, the stored
// position is reduced one page step of 132 per cycle and the scan is set up,
// then min(44, width - page start) columns of the page are scanned once
// through the single store port for the last nonzero column, the offsets are
// set, then the columns are read through the same port at one per cycle while
// the output is not stalled, and the buffer and output registers drain.
// The bitmap width register may be written only while the block is idle.
`default_nettype none
module led_laser_sweep_frames_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [lsf_pkg::OPC_W-1:0]   i_opcode,
    input  wire logic [lsf_pkg::COL_AW-1:0]  i_column_address,
    input  wire logic [lsf_pkg::PIX_W-1:0]   i_column_value,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [lsf_pkg::LCOL_W-1:0]       o_led_column,
    output logic [lsf_pkg::PIX_W-1:0]        o_pixel_bits,
    output logic                             o_last_column,
    output logic [lsf_pkg::POS_W-1:0]        o_cycle_position,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [lsf_pkg::WID_W-1:0]   i_cfg_data
);
    import lsf_pkg::*;

    logic q_valid;
    t_cmd q_cmd;
    logic q_take;

    assign o_cfg_ready = 1'b1;

    lsf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_column_address (i_column_address),
        .i_column_value   (i_column_value),
        .o_q_valid        (q_valid),
        .o_q_cmd          (q_cmd),
        .i_q_take         (q_take)
    );

    lsf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_q_valid        (q_valid),
        .i_q_cmd          (q_cmd),
        .o_q_take         (q_take),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_led_column     (o_led_column),
        .o_pixel_bits     (o_pixel_bits),
        .o_last_column    (o_last_column),
        .o_cycle_position (o_cycle_position)
    );

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// Testbench for the laser-sweep LED frame generator: frame predictor, scoreboard and drivers.
`timescale 1ns / 1ps

module tb;
    import lsf_pkg::*;

    localparam int QUIET_CYCLES = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int STUCK_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 12;

    typedef struct packed {
        logic [LCOL_W-1:0] col;
        logic [PIX_W-1:0]  pix;
        logic              last;
        logic [POS_W-1:0]  pos;
    } t_led_column;

    class t_frame_scoreboard;
        bit [PIX_W-1:0] bitmap [MAX_BITMAP_COLS];
        bit             written [MAX_BITMAP_COLS];
        logic [WID_W-1:0] width_reg = WID_W'(1);
        int position = 0;
        int mismatches = 0;
        t_led_column pending_columns[$];

        task report(string what);
            if (mismatches < 50)
                $display("ERROR %0t: %s", $time, what);
            mismatches++;
        endtask

        function int eff_width();
            if (width_reg == 0)
                return 1;
            if (int'(width_reg) > MAX_BITMAP_COLS)
                return MAX_BITMAP_COLS;
            return int'(width_reg);
        endfunction

        function int cycle_length();
            return PAGE_STEPS * ((eff_width() + DISPLAY_COLS - 1) / DISPLAY_COLS);
        endfunction

        function int page_start();
            return ((position % cycle_length()) / PAGE_STEPS) * DISPLAY_COLS;
        endfunction

        function logic [PIX_W-1:0] stored_column(int idx, int w);
            if (idx < 0 || idx >= w)
                return '0;
            return bitmap[idx];
        endfunction

        function int wrap(int a, int b);
            return ((a % b) + b) % b;
        endfunction

        function void predict_frame();
            int w, total, p, c, start, content, off, span, live_end, nxt, r;
            logic [PIX_W-1:0] v;
            t_led_column res;
            w = eff_width();
            total = cycle_length();
            p = position % total;
            c = p % PAGE_STEPS;
            start = page_start();
            content = 0;
            for (int k = 0; k < DISPLAY_COLS && start + k < w; k++)
                if (bitmap[start + k] != 0)
                    content = k + 1;
            off = (content < DISPLAY_COLS) ? (DISPLAY_COLS - content) / 2 : 0;
            span = DISPLAY_COLS - off;
            live_end = off + ((span < w - start) ? span : w - start);
            nxt = (p + 1) % total;
            position = nxt;
            for (int j = 0; j < DISPLAY_COLS; j++) begin
                v = '0;
                if (c < DISPLAY_COLS) begin
                    r = wrap(c - DISPLAY_COLS, span);
                    if (j >= off && j < off + r)
                        v = stored_column(start + j - off, w);
                    else if (j >= off + r && j < live_end)
                        v = stored_column(start + r, w);
                end else if (c < 2 * DISPLAY_COLS) begin
                    if (j >= off)
                        v = stored_column(start + j - off, w);
                end else begin
                    r = wrap(c - 2 * DISPLAY_COLS, span);
                    if (j >= off + r && j < live_end)
                        v = stored_column(start + j - off, w);
                end
                res.col = LCOL_W'(j);
                res.pix = v;
                res.last = (j == DISPLAY_COLS - 1);
                res.pos = POS_W'(nxt);
                pending_columns.push_back(res);
            end
        endfunction

        function void note_request(t_opcode op, logic [COL_AW-1:0] addr,
                                   logic [PIX_W-1:0] value);
            case (op)
                OP_WRITE: begin
                    bitmap[addr] = value;
                    written[addr] = 1'b1;
                end
                OP_RESTART: position = 0;
                OP_TICK: predict_frame();
                default: ;
            endcase
        endfunction

        task check_column(t_led_column got);
            t_led_column exp_col;
            if (pending_columns.size() == 0) begin
                report($sformatf("unexpected column %0d", got.col));
                return;
            end
            exp_col = pending_columns.pop_front();
            if (got.col !== exp_col.col)
                report($sformatf("led_column %0d, want %0d", got.col, exp_col.col));
            if (got.pix !== exp_col.pix)
                report($sformatf("pixel_bits %h, want %h at column %0d",
                                 got.pix, exp_col.pix, exp_col.col));
            if (got.last !== exp_col.last)
                report($sformatf("last_column %b, want %b at column %0d",
                                 got.last, exp_col.last, exp_col.col));
            if (got.pos !== exp_col.pos)
                report($sformatf("cycle_position %0d, want %0d at column %0d",
                                 got.pos, exp_col.pos, exp_col.col));
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic [OPC_W-1:0]   i_opcode = '0;
    logic [COL_AW-1:0]  i_column_address = '0;
    logic [PIX_W-1:0]   i_column_value = '0;
    logic               i_out_stall = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic [WID_W-1:0]   i_cfg_data = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [LCOL_W-1:0]  o_led_column;
    logic [PIX_W-1:0]   o_pixel_bits;
    logic               o_last_column;
    logic [POS_W-1:0]   o_cycle_position;
    logic               o_cfg_ready;

    t_frame_scoreboard sb = new();
    int send_idle_pct = 18;
    int recv_idle_pct = 66;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int stuck_cycles = 0;

    led_laser_sweep_frames_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_column_address (i_column_address),
        .i_column_value   (i_column_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_led_column     (o_led_column),
        .o_pixel_bits     (o_pixel_bits),
        .o_last_column    (o_last_column),
        .o_cycle_position (o_cycle_position),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // column sink: long hold on request, random stall otherwise
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_column({o_led_column, o_pixel_bits, o_last_column, o_cycle_position});
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin
        while (stuck_cycles < STUCK_LIMIT)
            @(posedge i_clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_request(t_opcode op, logic [COL_AW-1:0] addr,
                                logic [PIX_W-1:0] value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_column_address <= addr;
        i_column_value <= value;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(op, addr, value);
    endtask

    // fill any unwritten column of the page the tick will show, then tick
    task automatic send_tick();
        int start, len, filled, k;
        start = sb.page_start();
        len = sb.eff_width() - start;
        if (len > DISPLAY_COLS)
            len = DISPLAY_COLS;
        filled = $urandom_range(0, len);
        for (k = 0; k < len; k++)
            if (!sb.written[start + k])
                send_request(OP_WRITE, COL_AW'(start + k),
                             PIX_W'((k < filled) ? $urandom : 0));
        send_request(OP_TICK, COL_AW'($urandom), PIX_W'($urandom));
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (sb.pending_columns.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_width(logic [WID_W-1:0] w);
        wait_drain();
        repeat (QUIET_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.width_reg = w;
    endtask

    task automatic random_request();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 72)
            send_tick();
        else if (pick < 83)
            send_request(OP_WRITE, COL_AW'($urandom_range(0, sb.eff_width() - 1)),
                         PIX_W'(($urandom_range(0, 3) == 0) ? 0 : $urandom));
        else if (pick < 95)
            send_request(OP_WRITE, COL_AW'($urandom_range(0, MAX_BITMAP_COLS - 1)),
                         PIX_W'($urandom));
        else if (pick < 99)
            send_request(OP_NONE, COL_AW'($urandom), PIX_W'($urandom));
        else
            send_request(OP_RESTART, COL_AW'($urandom), PIX_W'($urandom));
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(OP_WRITE, '0, 16'hFFFF);
        send_tick();
        send_tick();
        send_request(OP_WRITE, 10'h3FF, 16'h0000);
        send_request(OP_WRITE, '0, 16'h0000);
        send_tick();
        send_request(OP_WRITE, '0, 16'h8001);
        send_request(OP_NONE, 10'h3FF, 16'hFFFF);
        send_tick();
        send_request(OP_RESTART, '0, '0);
        send_tick();
        set_width('0);
        send_tick();
        set_width('1);
        send_tick();
        send_tick();
        set_width(WID_W'(MAX_BITMAP_COLS));
        send_tick();
        set_width(WID_W'(DISPLAY_COLS + 1));
        send_tick();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: set_width(WID_W'($urandom_range(2, DISPLAY_COLS - 1)));
                1: begin
                    send_idle_pct = 66;
                    recv_idle_pct <= 18;
                    set_width(WID_W'($urandom_range(DISPLAY_COLS + 1, 3 * DISPLAY_COLS)));
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                    set_width(WID_W'(DISPLAY_COLS));
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i == PHASE_ITEMS / 2 && ph == 1)
                    wait_drain();
                if (i == PHASE_ITEMS / 2 && ph == 2) begin
                    hold_token <= hold_token + 1;
                    repeat (8) send_tick();
                end
                random_request();
            end
        end

        wait_drain();
        repeat (QUIET_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
